### hdl/sqrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrs_pkg
// Types, register codes and constants of the sprite quad rotate/scale block.
// ----------------------------------------------------------------------------
package sqrs_pkg;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        scale_x;
        logic [15:0]        scale_y;
        logic [12:0]        rotation_deg;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [11:0]        tex_off_x;
        logic [11:0]        tex_off_y;
        logic [31:0]        color_rgba;
    } t_sprite_in;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [19:0] vtx_x;
        logic signed [19:0] vtx_y;
        logic [19:0]        tex_u;
        logic [19:0]        tex_v;
        logic [31:0]        out_color;
        logic               last_corner;
    } t_vertex_out;

    // corner tag carried alongside the datapath
    typedef struct packed {
        logic [1:0]  corner;
        logic [31:0] color;
    } t_tag;

    localparam logic [1:0] REG_TEX_W = 2'd0;
    localparam logic [1:0] REG_TEX_H = 2'd1;
    localparam logic [1:0] REG_DSP_X = 2'd2;
    localparam logic [1:0] REG_DSP_Y = 2'd3;

    localparam logic [12:0] FULL_TURN_Q4 = 13'd5760;
    localparam int          ANGLE_NW     = 25;
    localparam int          ANGLE_SHIFT  = 40;
    localparam logic [27:0] ANGLE_RECIP  =
        28'(((64'd1 << ANGLE_SHIFT) + 64'd5759) / 64'd5760);
    localparam logic [ANGLE_NW-1:0] HALF_TURN_Q4 = ANGLE_NW'(2880);

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] HALF_PI = 64'd1686629713;

    // Q1.14 sine of a phase in 2^-32 turn units (table build only)
    function automatic logic signed [15:0] sine_of_phase(input logic [31:0] ph);
        logic [63:0] f;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        f = {34'd0, ph[29:0]};
        if (ph[30]) begin
            f = Q30_ONE - f;
        end
        x  = (f * HALF_PI) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + 64'd32768) >> 16;
        return ph[31] ? -$signed(s[15:0]) : $signed(s[15:0]);
    endfunction

endpackage

### hdl/sqrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrs_div
// Four-stage pipelined restoring divider, five quotient bits per stage.
// ----------------------------------------------------------------------------
module sqrs_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [28:0] i_num,
    input  logic [12:0] i_den,
    input  logic        i_sat,
    output logic [19:0] o_quo,
    output logic        o_sat
);
    import sqrs_pkg::*;

    logic [28:0] r_rem [4];
    logic [19:0] r_quo [4];
    logic        r_sat [4];
    logic [28:0] n_rem [4];
    logic [19:0] n_quo [4];

    always_comb begin
        logic [32:0] rem;
        logic [32:0] sub;
        int          bi;
        int          ps;
        for (int s = 0; s < 4; s++) begin
            ps       = (s == 0) ? 0 : s - 1;
            rem      = (s == 0) ? {4'd0, i_num} : {4'd0, r_rem[ps]};
            n_quo[s] = (s == 0) ? 20'd0 : r_quo[ps];
            for (int b = 0; b < 5; b++) begin
                bi  = 19 - 5 * s - b;
                sub = {20'd0, i_den} << bi;
                if (rem >= sub) begin
                    rem          = rem - sub;
                    n_quo[s][bi] = 1'b1;
                end
            end
            n_rem[s] = rem[28:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= i_sat;
            for (int s = 0; s < 4; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
            end
            for (int s = 1; s < 4; s++) begin
                r_sat[s] <= r_sat[s-1];
            end
        end
    end

    assign o_quo = r_quo[3];
    assign o_sat = r_sat[3];

endmodule

### hdl/sqrs_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrs_angle
// Angle to sine and cosine: reduce, scale to a table index, look up.
// Three register stages.
// ----------------------------------------------------------------------------
module sqrs_angle #(
    parameter int DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [12:0]        i_rot,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);
    import sqrs_pkg::*;

    localparam int IW = $clog2(DEPTH);

    typedef logic signed [15:0] t_trig_tab [DEPTH];

    function automatic t_trig_tab build_tab(input logic cos_sel);
        t_trig_tab   tab;
        logic [63:0] ph;
        for (int i = 0; i < DEPTH; i++) begin
            ph = (64'(i) << 32) / DEPTH;
            if (cos_sel) begin
                ph = ph + 64'h4000_0000;
            end
            tab[i] = sine_of_phase(ph[31:0]);
        end
        return tab;
    endfunction

    localparam t_trig_tab SIN_TAB = build_tab(1'b0);
    localparam t_trig_tab COS_TAB = build_tab(1'b1);

    logic [ANGLE_NW-1:0] r_num;
    logic [IW-1:0]       r_idx;
    logic [12:0]         a;
    logic [52:0]         prod;
    logic [IW:0]         k;

    assign a    = (i_rot >= FULL_TURN_Q4) ? i_rot - FULL_TURN_Q4 : i_rot;
    assign prod = 53'(r_num) * 53'(ANGLE_RECIP);
    assign k    = prod[ANGLE_SHIFT +: IW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= ANGLE_NW'(a) * ANGLE_NW'(DEPTH) + HALF_TURN_Q4;
            // index of a full turn wraps to zero
            r_idx <= (k >= (IW+1)'(DEPTH)) ? '0 : k[IW-1:0];
            o_sin <= SIN_TAB[r_idx];
            o_cos <= COS_TAB[r_idx];
        end
    end

endmodule

### hdl/sprite_quad_rotate_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_quad_rotate_scale
// Sprite to four rotated, scaled, textured corner vertices.
// ----------------------------------------------------------------------------
// One sprite word yields four vertex words, corners 0 to 3 in order, one per
// cycle while the output is not stalled; the corner sequencer at the input
// sets that rate and takes the next sprite word when idle or as the last
// corner of the current one goes into the pipeline. Each corner runs through
// a six-stage pipeline (angle table lookup, scale multiplies, rotation
// multiplies, sum and saturate, and a four-stage texture-coordinate divider
// alongside). A stall on the output holds the whole pipeline. The
// sine/cosine tables hold SINE_TABLE_DEPTH entries per turn.
module sprite_quad_rotate_scale #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sqrs_pkg::t_sprite_in  i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output sqrs_pkg::t_vertex_out o_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data
);
    import sqrs_pkg::*;

    logic [12:0] r_tex_w;
    logic [12:0] r_tex_h;
    logic [15:0] r_dsp_x;
    logic [15:0] r_dsp_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w <= 13'd256;
            r_tex_h <= 13'd256;
            r_dsp_x <= 16'd4096;
            r_dsp_y <= 16'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TEX_W: r_tex_w <= i_cfg_data[12:0];
                REG_TEX_H: r_tex_h <= i_cfg_data[12:0];
                REG_DSP_X: r_dsp_x <= i_cfg_data;
                REG_DSP_Y: r_dsp_y <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // corner sequencer
    // ------------------------------------------------------------------
    logic       r_v [1:6];
    logic       en;
    t_sprite_in r_spr;
    logic       r_sv;
    logic [1:0] r_cnt;
    logic       accept;

    assign en      = !(r_v[6] && i_stall);
    assign o_stall = r_sv && !(en && r_cnt == 2'd3);
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (en && r_sv) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_sv <= 1'b0;
                end
            end
            if (accept) begin
                r_sv  <= 1'b1;
                r_cnt <= 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_spr <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 6; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_v[1] <= r_sv;
            for (int s = 2; s <= 6; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    t_tag r_tag [1:5];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[1] <= '{corner: r_cnt, color: r_spr.color_rgba};
            for (int s = 2; s <= 5; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // angle
    // ------------------------------------------------------------------
    logic signed [15:0] sn;
    logic signed [15:0] cs;

    sqrs_angle #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_angle (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rot (r_spr.rotation_deg),
        .o_sin (sn),
        .o_cos (cs)
    );

    // ------------------------------------------------------------------
    // geometry
    // ------------------------------------------------------------------
    logic signed [18:0] r1_rx, r1_ry;
    logic [31:0]        r1_sdx, r1_sdy;
    logic signed [47:0] r_off_x [1:4];
    logic signed [47:0] r_off_y [1:4];
    logic signed [51:0] r2_px, r2_py;
    logic signed [43:0] r3_ax, r3_ay;
    logic signed [59:0] r4_xc, r4_ys, r4_xs, r4_yc;
    logic signed [35:0] r5_vx, r5_vy;

    logic signed [18:0] rx_c, ry_c;
    logic signed [32:0] pdx, pdy;
    logic signed [61:0] sum_x, sum_y;

    assign rx_c = $signed({2'b00, (r_cnt[0] ? {r_tex_w, 4'd0} : 17'd0)})
                  - 19'(r_spr.center_x);
    assign ry_c = $signed({2'b00, (r_cnt[1] ? {r_tex_h, 4'd0} : 17'd0)})
                  - 19'(r_spr.center_y);
    assign pdx  = 33'(r_spr.pos_x) * $signed({17'd0, r_dsp_x});
    assign pdy  = 33'(r_spr.pos_y) * $signed({17'd0, r_dsp_y});

    assign sum_x = 62'(r4_xc) - 62'(r4_ys) + 62'(r_off_x[4]);
    assign sum_y = 62'(r4_xs) + 62'(r4_yc) + 62'(r_off_y[4]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_rx  <= rx_c;
            r1_ry  <= ry_c;
            r1_sdx <= 32'(r_spr.scale_x) * 32'(r_dsp_x);
            r1_sdy <= 32'(r_spr.scale_y) * 32'(r_dsp_y);
            // position, pivot and the minus-half-pixel bias, all in Q30
            r_off_x[1] <= (48'(pdx) <<< 14) + (48'(r_spr.center_x) <<< 26)
                          - 48'sd536870912;
            r_off_y[1] <= (48'(pdy) <<< 14) + (48'(r_spr.center_y) <<< 26)
                          - 48'sd536870912;
            for (int s = 2; s <= 4; s++) begin
                r_off_x[s] <= r_off_x[s-1];
                r_off_y[s] <= r_off_y[s-1];
            end

            r2_px <= 52'(r1_rx) * $signed({20'd0, r1_sdx});
            r2_py <= 52'(r1_ry) * $signed({20'd0, r1_sdy});

            r3_ax <= 44'((r2_px + 52'sd128) >>> 8);
            r3_ay <= 44'((r2_py + 52'sd128) >>> 8);

            r4_xc <= 60'(r3_ax) * 60'(cs);
            r4_ys <= 60'(r3_ay) * 60'(sn);
            r4_xs <= 60'(r3_ax) * 60'(sn);
            r4_yc <= 60'(r3_ay) * 60'(cs);

            r5_vx <= 36'((sum_x + 62'sd33554432) >>> 26);
            r5_vy <= 36'((sum_y + 62'sd33554432) >>> 26);
        end
    end

    // ------------------------------------------------------------------
    // texture coordinates: left/top value by division, right/bottom adds one
    // unless the texture size is zero
    // ------------------------------------------------------------------
    logic [12:0] dw, dh;
    logic [28:0] r1_nu, r1_nv;
    logic        r1_su, r1_sv;
    logic [28:0] nu, nv;
    logic [19:0] qu, qv;
    logic        su, sv;

    assign dw = (r_tex_w == 13'd0) ? 13'd1 : r_tex_w;
    assign dh = (r_tex_h == 13'd0) ? 13'd1 : r_tex_h;
    assign nu = {r_spr.tex_off_x, 16'd0} + 29'(dw >> 1);
    assign nv = {r_spr.tex_off_y, 16'd0} + 29'(dh >> 1);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_nu <= nu;
            r1_nv <= nv;
            r1_su <= 33'(nu) >= {dw, 20'd0};
            r1_sv <= 33'(nv) >= {dh, 20'd0};
        end
    end

    sqrs_div u_div_u (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r1_nu),
        .i_den (dw),
        .i_sat (r1_su),
        .o_quo (qu),
        .o_sat (su)
    );

    sqrs_div u_div_v (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r1_nv),
        .i_den (dh),
        .i_sat (r1_sv),
        .o_quo (qv),
        .o_sat (sv)
    );

    // ------------------------------------------------------------------
    // output word
    // ------------------------------------------------------------------
    function automatic logic signed [19:0] sat20(input logic signed [35:0] v);
        if (v > 36'sd524287) begin
            return 20'sd524287;
        end else if (v < -36'sd524288) begin
            return -20'sd524288;
        end
        return v[19:0];
    endfunction

    function automatic logic [19:0] tex_sel(input logic [19:0] q, input logic s,
                                            input logic far_side);
        logic [20:0] t;
        t = {1'b0, q} + (far_side ? 21'd65536 : 21'd0);
        if (s || t[20]) begin
            return 20'hFFFFF;
        end
        return t[19:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_data.corner      <= r_tag[5].corner;
            o_data.vtx_x       <= sat20(r5_vx);
            o_data.vtx_y       <= sat20(r5_vy);
            o_data.tex_u       <= tex_sel(qu, su,
                                          r_tag[5].corner[0] && (r_tex_w != 13'd0));
            o_data.tex_v       <= tex_sel(qv, sv,
                                          r_tag[5].corner[1] && (r_tex_h != 13'd0));
            o_data.out_color   <= r_tag[5].color;
            o_data.last_corner <= (r_tag[5].corner == 2'd3);
        end
    end

    assign o_valid = r_v[6];

endmodule
